FILE: rtl/pcc_pkg.sv
package pcc_pkg;

	localparam int DIV_W = 64;

	localparam logic [1:0] REG_CAL_T    = 2'd0;
	localparam logic [1:0] REG_CAL_P1P4 = 2'd1;
	localparam logic [1:0] REG_CAL_P5P8 = 2'd2;
	localparam logic [1:0] REG_CAL_P9   = 2'd3;

	localparam logic signed [63:0] T_OFFSET   = 64'sd128000;
	localparam logic [20:0]        P_BIAS     = 21'd1048576;
	localparam logic [63:0]        P_SCALE    = 64'd3125;
	localparam logic [63:0]        A_BIAS     = 64'h0000_8000_0000_0000;
	localparam logic [31:0]        T_ROUND    = 32'd128;

endpackage

FILE: rtl/pcc_mul64.sv
module pcc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] lo_c;
	logic [31:0] cr_c;
	logic [63:0] lo_s1;
	logic [31:0] cr_s1;
	logic [63:0] p_s2;

	assign lo_c = a[31:0] * b[31:0];
	assign cr_c = a[63:32] * b[31:0] + a[31:0] * b[63:32];

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= lo_c;
			cr_s1 <= cr_c;
			p_s2  <= lo_s1 + {cr_s1, 32'd0};
		end
	end

	assign p = p_s2;

endmodule

FILE: rtl/pcc_div64.sv
module pcc_div64 #(
	parameter int SIDE_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  logic [pcc_pkg::DIV_W-1:0]           num,
	input  logic [pcc_pkg::DIV_W-1:0]           den,
	input  logic [SIDE_W-1:0]                   side_in,
	output logic                                vld_out,
	output logic [pcc_pkg::DIV_W-1:0]           quo,
	output logic [SIDE_W-1:0]                   side_out
);

	import pcc_pkg::*;

	logic [DIV_W-1:0]  rem_s  [0:DIV_W];
	logic [DIV_W-1:0]  quo_s  [0:DIV_W];
	logic [DIV_W-1:0]  den_s  [0:DIV_W];
	logic [SIDE_W-1:0] side_s [0:DIV_W];
	logic              vld_s  [0:DIV_W];

	assign rem_s[0]  = '0;
	assign quo_s[0]  = num;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;
	assign vld_s[0]  = vld_in;

	for (genvar k = 1; k <= DIV_W; k++) begin : g_step
		logic [DIV_W:0] shl;
		logic [DIV_W:0] trial;
		logic           ge;

		assign shl   = {rem_s[k-1], quo_s[k-1][DIV_W-1]};
		assign trial = shl - {1'b0, den_s[k-1]};
		assign ge    = !trial[DIV_W];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? trial[DIV_W-1:0] : shl[DIV_W-1:0];
				quo_s[k]  <= {quo_s[k-1][DIV_W-2:0], ge};
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign vld_out  = vld_s[DIV_W];
	assign quo      = quo_s[DIV_W];
	assign side_out = side_s[DIV_W];

endmodule

FILE: rtl/pressure_temp_compensation_core.sv
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    adc_temperature, adc_pressure
// output   out        out_valid / out_stall  temperature_centi, fine_temperature,
//                                            pressure_pa, pressure_invalid
// config   in         cfg_we                 cfg_index, cfg_data
//
// One transaction is accepted every cycle while the output is not stalled.
// The pressure path runs through the 64-stage restoring divider, one quotient bit per stage.
// Reset clears the valid bits and the calibration registers.
// A stalled output freezes the whole pipeline, and in_stall follows it.
module pressure_temp_compensation_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        adc_temperature,
	input  logic [19:0]        adc_pressure,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temperature_centi,
	output logic signed [31:0] fine_temperature,
	output logic [31:0]        pressure_pa,
	output logic               pressure_invalid,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	import pcc_pkg::*;

	localparam int SIDE_W = 66;

	logic        en;
	logic [47:0] cal_t_q;
	logic [63:0] cal_p14_q;
	logic [63:0] cal_p58_q;
	logic [15:0] cal_p9_q;

	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = cal_t_q[15:0];
	assign t2 = cal_t_q[31:16];
	assign t3 = cal_t_q[47:32];
	assign p1 = cal_p14_q[15:0];
	assign p2 = cal_p14_q[31:16];
	assign p3 = cal_p14_q[47:32];
	assign p4 = cal_p14_q[63:48];
	assign p5 = cal_p58_q[15:0];
	assign p6 = cal_p58_q[31:16];
	assign p7 = cal_p58_q[47:32];
	assign p8 = cal_p58_q[63:48];
	assign p9 = cal_p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q   <= '0;
			cal_p14_q <= '0;
			cal_p58_q <= '0;
			cal_p9_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_T:    cal_t_q   <= cfg_data[47:0];
				REG_CAL_P1P4: cal_p14_q <= cfg_data;
				REG_CAL_P5P8: cal_p58_q <= cfg_data;
				REG_CAL_P9:   cal_p9_q  <= cfg_data[15:0];
				default:      cal_p9_q  <= cal_p9_q;
			endcase
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic vld_s [1:13];
	logic vld_d;
	logic vld_p [78:83];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 13; i++) vld_s[i] <= 1'b0;
			for (int i = 78; i <= 83; i++) vld_p[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= 13; i++) vld_s[i] <= vld_s[i-1];
			vld_p[78] <= vld_d;
			for (int i = 79; i <= 83; i++) vld_p[i] <= vld_p[i-1];
		end
	end

	// Temperature path.
	logic signed [17:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic [19:0]        adcp_s [1:10];
	logic signed [33:0] m1_s2, m2_s2;
	logic signed [31:0] sq_c;
	logic signed [31:0] v1_s3;
	logic signed [47:0] m3_s3;
	logic signed [31:0] tfine_s [4:13];
	logic [31:0]        tc5_c;
	logic signed [31:0] tcenti_s [5:13];
	logic signed [63:0] a_s5;

	assign sq_c  = $signed(m2_s2[31:0]) >>> 12;
	assign tc5_c = {tfine_s[4][29:0], 2'b00} + tfine_s[4] + T_ROUND;

	// Pressure path ahead of the divider.
	logic [63:0]        aa_c, b1_c, c1_c, y_c;
	logic signed [49:0] ap5_s [6:9];
	logic signed [49:0] ap2_s [6:9];
	logic signed [63:0] b_s10, x_s10;
	logic [20:0]        pm_c;
	logic [63:0]        n_s11, num_s12;
	logic signed [63:0] den_c;
	logic [63:0]        an_s13, ad_s13;
	logic               neg_s13, zero_s13;

	assign pm_c  = P_BIAS - {1'b0, adcp_s[10]};
	assign den_c = $signed(y_c) >>> 33;

	pcc_mul64 u_mul_aa (
		.clk(clk), .en(en), .a(a_s5), .b(a_s5), .p(aa_c)
	);
	pcc_mul64 u_mul_b (
		.clk(clk), .en(en), .a(aa_c), .b(64'(p6)), .p(b1_c)
	);
	pcc_mul64 u_mul_c (
		.clk(clk), .en(en), .a(aa_c), .b(64'(p3)), .p(c1_c)
	);
	pcc_mul64 u_mul_y (
		.clk(clk), .en(en), .a(x_s10), .b({48'd0, p1}), .p(y_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1     <= $signed({1'b0, adc_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
			d2_s1     <= $signed({1'b0, adc_temperature[19:4]}) - $signed({1'b0, t1});
			adcp_s[1] <= adc_pressure;
			for (int i = 2; i <= 10; i++) adcp_s[i] <= adcp_s[i-1];

			m1_s2 <= d1_s1 * t2;
			m2_s2 <= d2_s1 * d2_s1;

			v1_s3 <= $signed(m1_s2[31:0]) >>> 11;
			m3_s3 <= sq_c * t3;

			tfine_s[4] <= v1_s3 + ($signed(m3_s3[31:0]) >>> 14);
			for (int i = 5; i <= 13; i++) tfine_s[i] <= tfine_s[i-1];

			tcenti_s[5] <= $signed(tc5_c) >>> 8;
			for (int i = 6; i <= 13; i++) tcenti_s[i] <= tcenti_s[i-1];
			a_s5 <= 64'(tfine_s[4]) - T_OFFSET;

			ap5_s[6] <= $signed(a_s5[33:0]) * p5;
			ap2_s[6] <= $signed(a_s5[33:0]) * p2;
			for (int i = 7; i <= 9; i++) begin
				ap5_s[i] <= ap5_s[i-1];
				ap2_s[i] <= ap2_s[i-1];
			end

			b_s10 <= $signed(b1_c) + (64'(ap5_s[9]) <<< 17) + (64'(p4) <<< 35);
			x_s10 <= $signed(A_BIAS) + ($signed(c1_c) >>> 8) + (64'(ap2_s[9]) <<< 12);

			n_s11   <= ({43'd0, pm_c} << 31) - b_s10;
			num_s12 <= n_s11 * P_SCALE;

			an_s13   <= num_s12[63] ? (64'd0 - num_s12) : num_s12;
			ad_s13   <= den_c[63] ? (64'd0 - den_c) : den_c;
			neg_s13  <= num_s12[63] ^ den_c[63];
			zero_s13 <= (den_c == 64'sd0);
		end
	end

	// Divider.
	logic [63:0]       q_d;
	logic [SIDE_W-1:0] side_d;

	pcc_div64 #(
		.SIDE_W(SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s[13]),
		.num      (an_s13),
		.den      (ad_s13),
		.side_in  ({neg_s13, zero_s13, tcenti_s[13], tfine_s[13]}),
		.vld_out  (vld_d),
		.quo      (q_d),
		.side_out (side_d)
	);

	// Pressure path after the divider.
	logic signed [63:0] p_s [78:81];
	logic signed [63:0] ph_c;
	logic [63:0]        sq2_c;
	logic signed [63:0] pd_s [79:81];
	logic signed [63:0] c1_s81;
	logic signed [63:0] s_s82;
	logic signed [63:0] f_c;
	logic               inv_s [78:83];
	logic signed [31:0] tc_s [78:83];
	logic signed [31:0] tf_s [78:83];
	logic [31:0]        press_s83;

	assign ph_c = p_s[78] >>> 13;
	assign f_c  = (s_s82 >>> 8) + (64'(p7) <<< 4);

	pcc_mul64 u_mul_sq (
		.clk(clk), .en(en), .a(ph_c), .b(ph_c), .p(sq2_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[78]  <= side_d[65] ? $signed(64'd0 - q_d) : $signed(q_d);
			inv_s[78] <= side_d[64];
			tc_s[78]  <= side_d[63:32];
			tf_s[78]  <= side_d[31:0];
			for (int i = 79; i <= 83; i++) begin
				inv_s[i] <= inv_s[i-1];
				tc_s[i]  <= tc_s[i-1];
				tf_s[i]  <= tf_s[i-1];
			end
			for (int i = 79; i <= 81; i++) p_s[i] <= p_s[i-1];

			pd_s[79] <= p_s[78] * 64'(p8);
			pd_s[80] <= pd_s[79];
			pd_s[81] <= pd_s[80];

			c1_s81 <= $signed(sq2_c) * 64'(p9);

			s_s82 <= p_s[81] + (c1_s81 >>> 25) + (pd_s[81] >>> 19);

			press_s83 <= inv_s[82] ? 32'd0 : f_c[39:8];
		end
	end

	assign out_valid         = vld_p[83];
	assign temperature_centi = tc_s[83];
	assign fine_temperature  = tf_s[83];
	assign pressure_pa       = press_s83;
	assign pressure_invalid  = inv_s[83];

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pressure_invalid) |-> (pressure_pa == 32'd0))
		else $error("invalid pressure with nonzero value");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s[13]) && $stable(vld_d) && $stable(vld_p[82])))
		else $error("pipeline moved while frozen");

endmodule

FILE: tb/tb_pressure_temp_compensation_core.sv
`timescale 1ns / 1ps

module tb_pressure_temp_compensation_core;
	import pcc_pkg::*;

	typedef struct packed {
		logic signed [31:0] t_centi;
		logic signed [31:0] t_fine;
		logic [31:0]        p_pa;
		logic               p_inv;
	} reading_t;

	typedef struct {
		logic [19:0] adc_t;
		logic [19:0] adc_p;
		logic        has_exp;
		reading_t    exp_r;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [19:0]        adc_temperature;
	logic [19:0]        adc_pressure;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] temperature_centi;
	logic signed [31:0] fine_temperature;
	logic [31:0]        pressure_pa;
	logic               pressure_invalid;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [63:0]        cfg_data;

	logic [47:0] cal_t;
	logic [63:0] cal_p14;
	logic [63:0] cal_p58;
	logic [15:0] cal_p9;

	reading_t expected_readings[$];
	int       mismatches;
	int       errors;
	longint   cycles;
	int       hold_off;
	bit       quiet_sink;

	pressure_temp_compensation_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.adc_temperature(adc_temperature),
		.adc_pressure(adc_pressure),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temperature_centi(temperature_centi),
		.fine_temperature(fine_temperature),
		.pressure_pa(pressure_pa),
		.pressure_invalid(pressure_invalid),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [63:0] sx16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
		reading_t r;
		logic [31:0] t1, t2, t3, d1, v1, d2, sq, v2, tf;
		logic signed [63:0] a, b, p, ph, c, d, an, ad, q;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] prod;
		logic neg;
		t1 = {16'd0, cal_t[15:0]};
		t2 = {{16{cal_t[31]}}, cal_t[31:16]};
		t3 = {{16{cal_t[47]}}, cal_t[47:32]};
		d1 = {15'd0, adc_t[19:3]} - (t1 << 1);
		prod = 64'(d1) * 64'(t2);
		v1 = 32'($signed(prod[31:0]) >>> 11);
		d2 = {16'd0, adc_t[19:4]} - t1;
		prod = 64'(d2) * 64'(d2);
		sq = 32'($signed(prod[31:0]) >>> 12);
		prod = 64'(sq) * 64'(t3);
		v2 = 32'($signed(prod[31:0]) >>> 14);
		tf = v1 + v2;
		r.t_fine = tf;
		r.t_centi = $signed(tf * 32'd5 + T_ROUND) >>> 8;
		p1 = {48'd0, cal_p14[15:0]};
		p2 = sx16(cal_p14[31:16]);
		p3 = sx16(cal_p14[47:32]);
		p4 = sx16(cal_p14[63:48]);
		p5 = sx16(cal_p58[15:0]);
		p6 = sx16(cal_p58[31:16]);
		p7 = sx16(cal_p58[47:32]);
		p8 = sx16(cal_p58[63:48]);
		p9 = sx16(cal_p9);
		a = {{32{tf[31]}}, tf} - T_OFFSET;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (($signed(A_BIAS) + a) * p1) >>> 33;
		r.p_pa = '0;
		r.p_inv = 1'b1;
		if (a != 0) begin
			p = 64'd1048576 - {44'd0, adc_p};
			p = ((p <<< 31) - b) * 64'sd3125;
			neg = p[63] ^ a[63];
			an = p[63] ? -p : p;
			ad = a[63] ? -a : a;
			q = $signed(64'($unsigned(an) / $unsigned(ad)));
			p = neg ? -q : q;
			ph = p >>> 13;
			c = (p9 * ph * ph) >>> 25;
			d = (p8 * p) >>> 19;
			p = ((p + c + d) >>> 8) + (p7 <<< 4);
			p = p >>> 8;
			r.p_pa = p[31:0];
			r.p_inv = 1'b0;
		end
		return r;
	endfunction

	task automatic write_cal(logic [1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_CAL_T: cal_t = val[47:0];
			REG_CAL_P1P4: cal_p14 = val;
			REG_CAL_P5P8: cal_p58 = val;
			default: cal_p9 = val[15:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_cal(logic [47:0] t, logic [63:0] a, logic [63:0] b, logic [15:0] c);
		write_cal(REG_CAL_T, {16'd0, t});
		write_cal(REG_CAL_P1P4, a);
		write_cal(REG_CAL_P5P8, b);
		write_cal(REG_CAL_P9, {48'd0, c});
	endtask

	task automatic send_sample(logic [19:0] at, logic [19:0] ap, bit gaps, bit has_exp,
			reading_t exp_r);
		while (gaps && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		adc_temperature <= at;
		adc_pressure <= ap;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_readings.push_back(has_exp ? exp_r : compensate(at, ap));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else if (quiet_sink) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 23);
		end
	end

	always @(posedge clk) begin
		reading_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{temperature_centi, fine_temperature, pressure_pa, pressure_invalid};
			if (expected_readings.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected transaction %p", got);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				if (got !== want) begin
					errors++;
					if (mismatches < 10)
						$display("mismatch: expected %p actual %p", want, got);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("tb_pressure_temp_compensation_core failed");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		reading_t zero_r;
		int n;
		cycles = 0;
		errors = 0;
		mismatches = 0;
		hold_off = 0;
		quiet_sink = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		adc_temperature = '0;
		adc_pressure = '0;
		cfg_we = 1'b0;
		cfg_index = REG_CAL_T;
		cfg_data = '0;
		cal_t = '0;
		cal_p14 = '0;
		cal_p58 = '0;
		cal_p9 = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With every coefficient at zero the divisor is zero, all values are zero and the pressure is flagged invalid.
		zero_r = '{32'sd0, 32'sd0, 32'd0, 1'b1};
		row = '{20'd0, 20'd0, 1'b1, zero_r};
		rows.push_back(row);
		row = '{20'hFFFFF, 20'hFFFFF, 1'b1, zero_r};
		rows.push_back(row);
		row = '{20'h55555, 20'hAAAAA, 1'b1, zero_r};
		rows.push_back(row);
		foreach (rows[i])
			send_sample(rows[i].adc_t, rows[i].adc_p, 1'b0, rows[i].has_exp, rows[i].exp_r);
		drain();

		// Typical datasheet-like calibration.
		load_cal({16'hFE0C, 16'd26435, 16'd27504},
			{16'sd2855, 16'hF50B, 16'hD6D0, 16'd36477},
			{16'hEC3C, 16'h3E62, 16'hFFF9, 16'hFF7D}, 16'sd6000);
		rows.delete();
		row = '{20'd519888, 20'd415148, 1'b0, zero_r};
		rows.push_back(row);
		row = '{20'd0, 20'd0, 1'b0, zero_r};
		rows.push_back(row);
		row = '{20'hFFFFF, 20'hFFFFF, 1'b0, zero_r};
		rows.push_back(row);
		row = '{20'h0, 20'hFFFFF, 1'b0, zero_r};
		rows.push_back(row);
		row = '{20'hFFFFF, 20'h0, 1'b0, zero_r};
		rows.push_back(row);
		foreach (rows[i])
			send_sample(rows[i].adc_t, rows[i].adc_p, 1'b1, rows[i].has_exp, rows[i].exp_r);
		drain();

		// Extreme coefficients: all ones, the most negative and the most positive signed values.
		load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 4; i++)
			send_sample(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0, 1'b1, 1'b0, zero_r);
		drain();
		load_cal(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000, 16'h8000);
		for (int i = 0; i < 4; i++)
			send_sample(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0, 1'b1, 1'b0, zero_r);
		drain();
		load_cal(48'h7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
		for (int i = 0; i < 4; i++)
			send_sample(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0, 1'b1, 1'b0, zero_r);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase % 2 == 0)
				load_cal({16'($urandom), 16'($urandom_range(20000, 30000)),
					16'($urandom_range(26000, 30000))},
					{16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(30000, 40000))},
					{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
					16'($urandom));
			else
				load_cal({$urandom, 16'($urandom)}, {$urandom, $urandom},
					{$urandom, $urandom}, 16'($urandom));
			quiet_sink = (phase == 2);
			if (phase == 3)
				hold_off <= 400;
			n = 250;
			for (int i = 0; i < n; i++) begin
				if (phase == 4 && i == 120)
					drain();
				if ($urandom_range(3) == 0)
					send_sample(20'($urandom), 20'($urandom), phase != 2, 1'b0, zero_r);
				else
					send_sample(20'($urandom_range(400000, 600000)),
						20'($urandom_range(200000, 700000)), phase != 2, 1'b0, zero_r);
			end
			drain();
		end
		quiet_sink = 1'b0;

		if (errors == 0)
			$display("tb_pressure_temp_compensation_core passed");
		else
			$display("tb_pressure_temp_compensation_core failed");
		$finish;
	end

endmodule
